[design/scsa_pkg.sv]
// Shared types, codes and sizing helpers of the size-class slab allocator.
`default_nettype none

package scsa_pkg;

  // Default geometry
  localparam int unsigned PAGE_BYTES_DEF    = 4096;
  localparam int unsigned CONTROL_BYTES_DEF = 16;
  localparam int unsigned CLASS_COUNT_DEF   = 6;

  // Fixed field widths
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned CLS_W  = 3;
  localparam int unsigned SIZE_W = 16;

  // Register indexes of the configuration port
  localparam int unsigned REG_SLAB_BASE = 0;

  // Request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_TOO_BIG = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_NO_SLAB = 3'd3,
    STAT_TAIL    = 3'd4
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CLS_W-1:0]  cls;
    status_e           st;
  } result_t;

  // Buffers that fit in front of the control tail of one page
  function automatic int unsigned bufs_in(input int unsigned c, input int unsigned page,
                                          input int unsigned ctrl);
    return (page - ctrl) >> (3 + c);
  endfunction

  // Byte offset of a class's page from the slab base
  function automatic int unsigned page_off(input int unsigned c, input int unsigned page);
    return c * page;
  endfunction

endpackage

`default_nettype wire

[design/scsa_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module scsa_ram #(
  parameter int unsigned W     = 9,
  parameter int unsigned DEPTH = 3072
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/scsa_front.sv]
// Front end: takes requests, picks the class and checks the free address.
`default_nettype none

module scsa_front import scsa_pkg::*; #(
  parameter int unsigned PAGE_BYTES    = PAGE_BYTES_DEF,
  parameter int unsigned CONTROL_BYTES = CONTROL_BYTES_DEF,
  parameter int unsigned CLASS_COUNT   = CLASS_COUNT_DEF,
  parameter int unsigned IDX_W         = 9,
  parameter int unsigned ITEM_W        = 1 + CLS_W + IDX_W + 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              req_type_i,
  input  wire logic [SIZE_W-1:0] request_size_i,
  input  wire logic [ADDR_W-1:0] free_address_i,
  input  wire logic [ADDR_W-1:0] slab_base_i,
  output logic                   stage_busy_o,
  output logic                   push_o,
  output logic [ITEM_W-1:0]      item_o
);

  localparam int unsigned OFF_W = $clog2(CLASS_COUNT * PAGE_BYTES);
  localparam int unsigned PG_W  = $clog2(PAGE_BYTES);

  typedef struct packed {
    logic             op;
    logic [CLS_W-1:0] cls;
    logic [IDX_W-1:0] idx;
    status_e          st;
  } item_t;

  logic              s1_valid_q;
  logic              s1_op_q, s1_op_d;
  logic [CLS_W-1:0]  s1_acls_q, s1_acls_d;
  logic              s1_big_q, s1_big_d;
  logic              s1_out_q, s1_out_d;
  logic [OFF_W-1:0]  s1_off_q, s1_off_d;
  logic [ADDR_W+1:0] diff;
  logic [CLS_W-1:0]  fcls;
  logic [OFF_W-1:0]  inpage;
  logic [PG_W-1:0]   idx_full;
  logic              tail;
  item_t             item;

  // Stage one: size compare for allocate, range check for free
  always_comb begin
    s1_op_d   = req_type_i;
    s1_big_d  = request_size_i > SIZE_W'(8 << (CLASS_COUNT - 1));
    s1_acls_d = '0;
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if (request_size_i <= SIZE_W'(8 << c)) begin
        s1_acls_d = CLS_W'(c);
      end
    end
    diff     = {2'b00, free_address_i} - {2'b00, slab_base_i};
    s1_out_d = diff[ADDR_W+1] || (diff >= (ADDR_W+2)'(CLASS_COUNT * PAGE_BYTES));
    s1_off_d = diff[OFF_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_op_q   <= s1_op_d;
      s1_big_q  <= s1_big_d;
      s1_acls_q <= s1_acls_d;
      s1_out_q  <= s1_out_d;
      s1_off_q  <= s1_off_d;
    end
  end

  // Stage two: page, buffer index and tail check
  always_comb begin
    fcls = '0;
    for (int k = 1; k < CLASS_COUNT; k++) begin
      if (s1_off_q >= OFF_W'(k * PAGE_BYTES)) begin
        fcls = CLS_W'(k);
      end
    end
    inpage   = s1_off_q - OFF_W'(page_off(fcls, PAGE_BYTES));
    idx_full = inpage[PG_W-1:0] >> (3 + fcls);
    tail     = idx_full >= PG_W'(bufs_in(fcls, PAGE_BYTES, CONTROL_BYTES));

    item.op  = s1_op_q;
    item.cls = '0;
    item.idx = '0;
    item.st  = STAT_OK;
    if (s1_op_q == OP_ALLOC) begin
      if (s1_big_q) begin
        item.st = STAT_TOO_BIG;
      end else begin
        item.cls = s1_acls_q;
      end
    end else begin
      if (s1_out_q) begin
        item.st = STAT_NO_SLAB;
      end else if (tail) begin
        item.st  = STAT_TAIL;
        item.cls = fcls;
      end else begin
        item.cls = fcls;
        item.idx = idx_full[IDX_W-1:0];
      end
    end
  end

  assign stage_busy_o = s1_valid_q;
  assign push_o       = s1_valid_q;
  assign item_o       = item;

endmodule

`default_nettype wire

[design/scsa_queue.sv]
// Two-entry queue between the front end and the back end.
`default_nettype none

module scsa_queue #(
  parameter int unsigned W = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic [W-1:0]      data_o,
  output logic              full_o
);

  logic [W-1:0] slot_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Hold the payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign data_o  = slot_q[rptr_q];

endmodule

`default_nettype wire

[design/scsa_back.sv]
// Back end: free lists, link memory, clearing pass and result register.
`default_nettype none

module scsa_back import scsa_pkg::*; #(
  parameter int unsigned PAGE_BYTES    = PAGE_BYTES_DEF,
  parameter int unsigned CONTROL_BYTES = CONTROL_BYTES_DEF,
  parameter int unsigned CLASS_COUNT   = CLASS_COUNT_DEF,
  parameter int unsigned IDX_W         = 9,
  parameter int unsigned CNT_W         = 9,
  parameter int unsigned ITEM_W        = 1 + CLS_W + IDX_W + 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ADDR_W-1:0] slab_base_i,
  input  wire logic              q_valid_i,
  input  wire logic [ITEM_W-1:0] q_item_i,
  output logic                   q_pop_o,
  output logic                   clearing_o,
  output logic                   res_valid_o,
  output result_t                res_o
);

  localparam int unsigned DEPTH  = CLASS_COUNT << IDX_W;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CIW    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

  typedef struct packed {
    logic             op;
    logic [CLS_W-1:0] cls;
    logic [IDX_W-1:0] idx;
    status_e          st;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_READ  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  head_q [CLASS_COUNT];
  logic [CNT_W-1:0]  cnt_q  [CLASS_COUNT];
  logic [CLS_W-1:0]  clr_cls_q;
  logic [IDX_W-1:0]  clr_idx_q;
  logic [CLS_W-1:0]  cur_cls_q;
  logic [IDX_W-1:0]  cur_idx_q;
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;
  item_t             item;
  logic [CLS_W-1:0]  sel_cls;
  logic [CIW-1:0]    sel;
  logic [CNT_W-1:0]  sel_bufs;
  logic [IDX_W:0]    clr_next;
  logic [IDX_W:0]    clr_bufs;
  logic              clr_last;
  logic [CLS_W+IDX_W-1:0] waddr_full, raddr_full;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [IDX_W-1:0]  wdata, rdata;
  logic [CLS_W-1:0]  emit_cls;
  logic [IDX_W-1:0]  emit_idx;
  logic [ADDR_W-1:0] emit_addr;
  logic              do_alloc, do_free, do_error, do_full;

  assign item     = item_t'(q_item_i);
  assign sel_cls  = (state_q == ST_READ) ? cur_cls_q : item.cls;
  assign sel      = sel_cls[CIW-1:0];
  assign sel_bufs = CNT_W'(bufs_in(sel_cls, PAGE_BYTES, CONTROL_BYTES));

  // Decode the queued item
  always_comb begin
    do_alloc = 1'b0;
    do_free  = 1'b0;
    do_error = 1'b0;
    do_full  = 1'b0;
    if (state_q == ST_IDLE && q_valid_i) begin
      if (item.st != STAT_OK) begin
        do_error = 1'b1;
      end else if (item.op == OP_FREE) begin
        do_free = 1'b1;
      end else if (cnt_q[sel] == '0) begin
        do_full = 1'b1;
      end else begin
        do_alloc = 1'b1;
      end
    end
  end

  // Clearing pass: re-thread every list in order
  assign clr_next = (IDX_W+1)'(clr_idx_q) + 1'b1;
  assign clr_bufs = (IDX_W+1)'(bufs_in(clr_cls_q, PAGE_BYTES, CONTROL_BYTES));
  assign clr_last = (clr_cls_q == CLS_W'(CLASS_COUNT - 1)) && (&clr_idx_q);

  // Link memory ports
  always_comb begin
    we         = 1'b0;
    wdata      = '0;
    waddr_full = {clr_cls_q, clr_idx_q};
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      wdata = (clr_next < clr_bufs) ? clr_next[IDX_W-1:0] : '0;
    end else if (do_free) begin
      we         = 1'b1;
      wdata      = head_q[sel];
      waddr_full = {item.cls, item.idx};
    end
    re         = do_alloc;
    raddr_full = {item.cls, head_q[sel]};
  end

  assign waddr = waddr_full[AW-1:0];
  assign raddr = raddr_full[AW-1:0];

  scsa_ram #(
    .W     (IDX_W),
    .DEPTH (DEPTH)
  ) u_link (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Buffer address of the result
  assign emit_cls  = (state_q == ST_READ) ? cur_cls_q : item.cls;
  assign emit_idx  = (state_q == ST_READ) ? cur_idx_q : item.idx;
  assign emit_addr = slab_base_i + ADDR_W'(page_off(emit_cls, PAGE_BYTES))
                   + (ADDR_W'(emit_idx) << (3 + emit_cls));

  // Next state and result
  always_comb begin
    state_d     = state_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (do_alloc) begin
          state_d = ST_READ;
        end
        if (do_error || do_full) begin
          res_valid_d = 1'b1;
          res_d.addr  = '0;
          res_d.cls   = item.cls;
          res_d.st    = do_full ? STAT_FULL : item.st;
        end else if (do_free) begin
          res_valid_d = 1'b1;
          res_d.addr  = emit_addr;
          res_d.cls   = item.cls;
          res_d.st    = STAT_OK;
        end
      end
      ST_READ: begin
        state_d     = ST_IDLE;
        res_valid_d = 1'b1;
        res_d.addr  = emit_addr;
        res_d.cls   = cur_cls_q;
        res_d.st    = STAT_OK;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // Control state and list registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      res_valid_q <= 1'b0;
      clr_cls_q   <= '0;
      clr_idx_q   <= '0;
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head_q[c] <= '0;
        cnt_q[c]  <= CNT_W'(bufs_in(c, PAGE_BYTES, CONTROL_BYTES));
      end
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (state_q == ST_CLEAR) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (&clr_idx_q) begin
          clr_cls_q <= clr_cls_q + 1'b1;
        end
      end
      if (do_free) begin
        head_q[sel] <= item.idx;
        if (cnt_q[sel] < sel_bufs) begin
          cnt_q[sel] <= cnt_q[sel] + 1'b1;
        end
      end
      if (state_q == ST_READ) begin
        head_q[sel] <= rdata;
        cnt_q[sel]  <= cnt_q[sel] - 1'b1;
      end
    end
  end

  // Hold the item in flight and the result payload
  always_ff @(posedge clk_i) begin
    if (do_alloc) begin
      cur_cls_q <= item.cls;
      cur_idx_q <= head_q[sel];
    end
    res_q <= res_d;
  end

  assign q_pop_o     = state_q == ST_IDLE && q_valid_i;
  assign clearing_o  = state_q == ST_CLEAR;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_IDLE)
    else $error("allocate read did not complete in one cycle");

  a_error_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.st != STAT_OK |-> res_q.addr == '0)
    else $error("failed beat carries a nonzero address");

  a_no_result_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |=> !res_valid_q)
    else $error("result beat during clearing pass");

  a_no_pop_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> !q_pop_o && !we)
    else $error("queue popped or memory written while allocate pending");
`endif

endmodule

`default_nettype wire

[design/size_class_slab_allocator.sv]
// Top level of the size-class slab allocator: register port and block wiring.
`default_nettype none

// Allocator for CLASS_COUNT size classes (8 << class bytes), each owning one
// page at slab_base + class * PAGE_BYTES. After reset a clearing pass
// re-threads all CLASS_COUNT << IDX_W link memory entries (3072 with the
// defaults), one entry a cycle; busy is high through it. A request is taken
// when start is high and busy low; busy stays high while the front end
// register holds it. A free, an error or a full class is answered from the
// back end's idle state; a successful allocate also passes its read state,
// since the link memory read of the list head is registered. A result beat
// appears on result_valid_o for exactly one cycle, and must be taken then;
// the receiver cannot stall. New requests enter while earlier ones wait.
// The user must write slab_base through the APB port only while idle; the block itself does not enforce it.
module size_class_slab_allocator import scsa_pkg::*; #(
  parameter int unsigned PAGE_BYTES    = PAGE_BYTES_DEF,
  parameter int unsigned CONTROL_BYTES = CONTROL_BYTES_DEF,
  parameter int unsigned CLASS_COUNT   = CLASS_COUNT_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic      [63:0]       prdata,
  output logic                   pready,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              req_type_i,
  input  wire logic [SIZE_W-1:0] request_size_i,
  input  wire logic [ADDR_W-1:0] free_address_i,
  output logic                   result_valid_o,
  output logic [ADDR_W-1:0]      buffer_address_o,
  output logic [CLS_W-1:0]       size_class_o,
  output logic [2:0]             status_o
);

  localparam int unsigned MAX_BUFS = (PAGE_BYTES - CONTROL_BYTES) / 8;
  localparam int unsigned IDX_W    = $clog2(MAX_BUFS);
  localparam int unsigned CNT_W    = $clog2(MAX_BUFS + 1);
  localparam int unsigned ITEM_W   = 1 + CLS_W + IDX_W + 3;

  logic [ADDR_W-1:0] slab_base_q;
  logic              accept;
  logic              stage_busy, q_full, clearing;
  logic              push, pop, q_valid;
  logic [ITEM_W-1:0] push_item, q_item;
  logic              sel_base;
  result_t           res;

  // Register port
  assign sel_base = paddr[3] == 1'(REG_SLAB_BASE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slab_base_q <= '0;
    end else if (psel && penable && pwrite && pready && sel_base) begin
      slab_base_q <= pwdata[ADDR_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = sel_base ? {16'h0000, slab_base_q} : 64'h0;

  // Request handshake
  assign busy   = clearing || stage_busy || q_full;
  assign accept = start && !busy;

  scsa_front #(
    .PAGE_BYTES    (PAGE_BYTES),
    .CONTROL_BYTES (CONTROL_BYTES),
    .CLASS_COUNT   (CLASS_COUNT),
    .IDX_W         (IDX_W),
    .ITEM_W        (ITEM_W)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .req_type_i     (req_type_i),
    .request_size_i (request_size_i),
    .free_address_i (free_address_i),
    .slab_base_i    (slab_base_q),
    .stage_busy_o   (stage_busy),
    .push_o         (push),
    .item_o         (push_item)
  );

  scsa_queue #(
    .W (ITEM_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_item),
    .full_o  (q_full)
  );

  scsa_back #(
    .PAGE_BYTES    (PAGE_BYTES),
    .CONTROL_BYTES (CONTROL_BYTES),
    .CLASS_COUNT   (CLASS_COUNT),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W),
    .ITEM_W        (ITEM_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slab_base_i (slab_base_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (pop),
    .clearing_o  (clearing),
    .res_valid_o (result_valid_o),
    .res_o       (res)
  );

  assign buffer_address_o = res.addr;
  assign size_class_o     = res.cls;
  assign status_o         = res.st;

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the size-class slab allocator: directed table, then random traffic.
`timescale 1ns / 1ps

module testbench;
  import scsa_pkg::*;

  localparam int unsigned NCLS   = CLASS_COUNT_DEF;
  localparam int unsigned PAGE   = PAGE_BYTES_DEF;
  localparam int unsigned CTRL   = CONTROL_BYTES_DEF;
  localparam int unsigned MAXBUF = (PAGE - CTRL) / 8;
  localparam logic [63:0] AMASK  = 64'hFFFF_FFFF_FFFF;
  localparam int unsigned PHASE_ITEMS = 225;

  typedef struct {
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    result_t           res;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic              req_type_i = OP_ALLOC;
  logic [SIZE_W-1:0] request_size_i = '0;
  logic [ADDR_W-1:0] free_address_i = '0;
  logic              result_valid_o;
  logic [ADDR_W-1:0] buffer_address_o;
  logic [CLS_W-1:0]  size_class_o;
  logic [2:0]        status_o;

  size_class_slab_allocator dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .req_type_i, .request_size_i, .free_address_i,
    .result_valid_o, .buffer_address_o, .size_class_o, .status_o
  );

  // Shadow allocator state
  logic [63:0] shadow_base;
  logic [9:0]  shadow_link [NCLS][MAXBUF];
  logic [9:0]  shadow_head [NCLS];
  logic [9:0]  shadow_count[NCLS];

  result_t          pending_grants[$];
  logic [ADDR_W-1:0] live_buffers[$];
  stim_row_t        directed_rows[$];
  bit               failed = 1'b0;
  bit               gaps_on = 1'b1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned bufs_of(input int unsigned c);
    return (PAGE - CTRL) >> (3 + c);
  endfunction

  function automatic void reset_shadow();
    for (int c = 0; c < NCLS; c++) begin
      for (int i = 0; i < MAXBUF; i++)
        shadow_link[c][i] = (i + 1 < bufs_of(c)) ? 10'(i + 1) : 10'd0;
      shadow_head[c]  = '0;
      shadow_count[c] = 10'(bufs_of(c));
    end
    shadow_base = '0;
  endfunction

  // Compute the grant for one request and advance the shadow state
  function automatic result_t predict_grant(input logic op, input logic [SIZE_W-1:0] size,
                                            input logic [ADDR_W-1:0] addr);
    result_t     r;
    int unsigned c;
    int unsigned idx;
    logic [63:0] a;
    logic [63:0] off;
    r = '{addr: '0, cls: '0, st: STAT_OK};
    if (op == OP_ALLOC) begin
      if (size > (8 << (NCLS - 1))) begin
        r.st = STAT_TOO_BIG;
        return r;
      end
      c = 0;
      while (c < NCLS - 1 && (8 << c) < size) c++;
      r.cls = CLS_W'(c);
      if (shadow_count[c] == 0) begin
        r.st = STAT_FULL;
        return r;
      end
      idx = shadow_head[c];
      if (idx >= MAXBUF) idx = 0;
      shadow_head[c] = shadow_link[c][idx];
      shadow_count[c]--;
      r.addr = ADDR_W'((shadow_base + c * PAGE + (idx << (3 + c))) & AMASK);
      return r;
    end
    a = {16'd0, addr};
    if (a < shadow_base || a >= shadow_base + NCLS * PAGE) begin
      r.st = STAT_NO_SLAB;
      return r;
    end
    off = a - shadow_base;
    c = int'(off / PAGE);
    r.cls = CLS_W'(c);
    idx = int'((off % PAGE) >> (3 + c));
    if (idx >= bufs_of(c)) begin
      r.st = STAT_TAIL;
      return r;
    end
    shadow_link[c][idx] = shadow_head[c];
    shadow_head[c] = 10'(idx);
    if (shadow_count[c] < bufs_of(c)) shadow_count[c]++;
    r.addr = ADDR_W'((shadow_base + c * PAGE + (idx << (3 + c))) & AMASK);
    return r;
  endfunction

  // Drive one request beat and wait for it to be taken
  task automatic issue(input logic op, input logic [SIZE_W-1:0] size,
                       input logic [ADDR_W-1:0] addr, input bit typed, input result_t res);
    result_t r;
    req_type_i     <= op;
    request_size_i <= size;
    free_address_i <= addr;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    r = predict_grant(op, size, addr);
    if (typed) r = res;
    if (r.st == STAT_OK && op == OP_ALLOC) live_buffers.push_back(r.addr);
    pending_grants.push_back(r);
  endtask

  // Hold start low for a random burst now and then
  task automatic maybe_idle();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Drain, then write slab_base with a setup and an access phase
  task automatic write_base(input logic [ADDR_W-1:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_grants.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 4'(REG_SLAB_BASE * 8);
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_base = {16'd0, value};
    live_buffers.delete();
  endtask

  task automatic add_row(input logic op, input logic [SIZE_W-1:0] size,
                         input logic [ADDR_W-1:0] addr, input bit typed,
                         input result_t res);
    stim_row_t row;
    row.op = op; row.size = size; row.addr = addr; row.typed = typed; row.res = res;
    directed_rows.push_back(row);
  endtask

  // Random request: mostly legal sizes and freed live buffers, some noise
  task automatic random_item();
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       wide;
    int unsigned       pick;
    int unsigned       k;
    pick = $urandom_range(0, 99);
    size = '0;
    addr = '0;
    if (pick < 45) begin
      k = $urandom_range(0, 9);
      if (k < 8)      size = SIZE_W'($urandom_range(0, 256));
      else if (k < 9) size = SIZE_W'($urandom_range(257, 65535));
      else            size = SIZE_W'($urandom());
      issue(OP_ALLOC, size, '0, 1'b0, '0);
      return;
    end
    k = $urandom_range(0, 99);
    if (k < 55 && live_buffers.size() != 0) begin
      pick = $urandom_range(0, live_buffers.size() - 1);
      addr = live_buffers[pick] + ADDR_W'($urandom_range(0, 7));
      live_buffers.delete(pick);
    end else if (k < 85) begin
      wide = shadow_base + $urandom_range(0, NCLS - 1) * PAGE + $urandom_range(0, PAGE - 1);
      addr = ADDR_W'(wide & AMASK);
    end else if (k < 92) begin
      wide = shadow_base + ($urandom_range(0, 1) ? -64'd1 : 64'(NCLS * PAGE));
      addr = ADDR_W'(wide & AMASK);
    end else begin
      addr = ADDR_W'({$urandom(), $urandom()});
    end
    size = SIZE_W'($urandom());
    issue(OP_FREE, size, addr, 1'b0, '0);
  endtask

  // Result checker: the receiver takes every beat
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_grants.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1'b1;
      end else begin
        want = pending_grants.pop_front();
        if (buffer_address_o !== want.addr) begin
          $error("buffer_address expected %h actual %h", want.addr, buffer_address_o);
          failed = 1'b1;
        end
        if (size_class_o !== want.cls) begin
          $error("size_class expected %0d actual %0d", want.cls, size_class_o);
          failed = 1'b1;
        end
        if (status_o !== want.st) begin
          $error("status expected %0d actual %0d", want.st, status_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Main sequence
  initial begin
    logic [ADDR_W-1:0] bases[4];
    reset_shadow();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows with slab_base at its reset value of zero
    add_row(OP_ALLOC, 16'd0,     '0, 1'b1, '{addr: '0, cls: 3'd0, st: STAT_OK});
    add_row(OP_ALLOC, 16'd8,     '0, 1'b0, '0);
    add_row(OP_ALLOC, 16'd9,     '0, 1'b0, '0);
    add_row(OP_ALLOC, 16'hFFFF,  '0, 1'b1, '{addr: '0, cls: 3'd0, st: STAT_TOO_BIG});
    add_row(OP_ALLOC, 16'd257,   '0, 1'b1, '{addr: '0, cls: 3'd0, st: STAT_TOO_BIG});
    add_row(OP_FREE, 16'hFFFF, ADDR_W'(NCLS * PAGE), 1'b1,
            '{addr: '0, cls: 3'd0, st: STAT_NO_SLAB});
    add_row(OP_FREE, 16'd0, {ADDR_W{1'b1}}, 1'b1, '{addr: '0, cls: 3'd0, st: STAT_NO_SLAB});
    add_row(OP_FREE, 16'd0, ADDR_W'(4088), 1'b1, '{addr: '0, cls: 3'd0, st: STAT_TAIL});
    add_row(OP_FREE, 16'd0, ADDR_W'(5 * PAGE + 3840), 1'b1,
            '{addr: '0, cls: 3'd5, st: STAT_TAIL});
    add_row(OP_FREE, 16'd0, ADDR_W'(8), 1'b0, '0);
    // Unaligned free of the same buffer: truncation plus double free
    add_row(OP_FREE, 16'd0, ADDR_W'(13), 1'b0, '0);
    add_row(OP_ALLOC, 16'd256, '0, 1'b0, '0);
    // Exhaust the largest class until it reports full
    for (int i = 0; i < 15; i++) add_row(OP_ALLOC, 16'd129, '0, 1'b0, '0);

    foreach (directed_rows[i]) begin
      maybe_idle();
      issue(directed_rows[i].op, directed_rows[i].size, directed_rows[i].addr,
            directed_rows[i].typed, directed_rows[i].res);
    end

    // Random phases over several slab bases, extremes among them
    bases[0] = 48'hFFFF_FFFF_F000;
    bases[1] = ADDR_W'({$urandom(), $urandom()});
    bases[2] = ADDR_W'({$urandom(), $urandom()}) & 48'hFFFF_FFFF_F000;
    bases[3] = '0;
    for (int p = 0; p < 4; p++) begin
      write_base(bases[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n >= PHASE_ITEMS / 2) gaps_on = 1'b0;
        maybe_idle();
        random_item();
      end
    end
    start <= 1'b0;

    // Drain and let the pipeline settle
    while (pending_grants.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[size_class_slab_allocator.f]
design/scsa_pkg.sv
design/scsa_ram.sv
design/scsa_front.sv
design/scsa_queue.sv
design/scsa_back.sv
design/size_class_slab_allocator.sv
verif/testbench.sv
